// ===== hdl/ctmm_pkg.sv =====
// Package: shared constants, types and helpers for the trimmed mean / median block
`timescale 1ns / 1ps
package ctmm_pkg;
    localparam int MAX_AGENTS = 8;
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(MAX_AGENTS + 1);
    localparam int SUM_W = VAL_W + $clog2(MAX_AGENTS);
    localparam int RANK_W = $clog2(MAX_AGENTS);
    localparam logic [1:0] REG_AGENT_COUNT = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;
    localparam logic [1:0] REG_TRIM_COUNT = 2'd2;
    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_TRIM = 1'b1;
    localparam int RECIP_W = 39;
    localparam int RECIP_SH = 38;
    localparam int RECIP_LO_W = 20;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic mode;
        logic [2:0] trim;
    } cfg_t;

    // select info carried per item alongside the lanes to merge
    typedef struct packed {
        logic empty;
        logic mode;
        logic [CNT_W-1:0] kept;
    } ctl_t;

    // ceil(2^RECIP_SH / d) for d = 1..8
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd1: r = 39'd274877906944;
            4'd2: r = 39'd137438953472;
            4'd3: r = 39'd91625968982;
            4'd4: r = 39'd68719476736;
            4'd5: r = 39'd54975581389;
            4'd6: r = 39'd45812984491;
            4'd7: r = 39'd39268272421;
            4'd8: r = 39'd34359738368;
            default: r = 39'd274877906944;
        endcase
        return r;
    endfunction
endpackage

// ===== hdl/ctmm_lane.sv =====
// Lane: rank one agent value against the others and flag whether it is kept
`timescale 1ns / 1ps
module ctmm_lane (
    input  logic aclk,
    input  logic en,
    input  logic [ctmm_pkg::RANK_W-1:0] lane_idx,
    input  ctmm_pkg::val_t vals [ctmm_pkg::MAX_AGENTS],
    input  ctmm_pkg::cfg_t cfg,
    output ctmm_pkg::val_t val_q,
    output logic [ctmm_pkg::RANK_W-1:0] rank_q,
    output logic keep_q,
    output logic med_q
);
    logic [ctmm_pkg::CNT_W-1:0] rank;
    logic used;
    logic [ctmm_pkg::CNT_W-1:0] hi_lim;
    ctmm_pkg::val_t val_reg;
    logic [ctmm_pkg::RANK_W-1:0] rank_reg;
    logic keep_reg, med_reg;

    // stable rank: smaller values, or equal values at lower index, come first
    always_comb begin
        rank = '0;
        for (int j = 0; j < ctmm_pkg::MAX_AGENTS; j++) begin
            if (ctmm_pkg::CNT_W'(j) < cfg.n && ctmm_pkg::RANK_W'(j) != lane_idx) begin
                if (vals[j] < vals[lane_idx] ||
                    (vals[j] == vals[lane_idx] && ctmm_pkg::RANK_W'(j) < lane_idx))
                    rank = rank + 1'b1;
            end
        end
        used = {1'b0, lane_idx} < cfg.n;
        hi_lim = cfg.n - {{(ctmm_pkg::CNT_W-3){1'b0}}, cfg.trim};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= vals[lane_idx];
            rank_reg <= rank[ctmm_pkg::RANK_W-1:0];
            keep_reg <= used && rank >= {1'b0, cfg.trim} && rank < hi_lim;
            med_reg <= used && rank == (cfg.n >> 1);
        end
    end

    assign val_q = val_reg;
    assign rank_q = rank_reg;
    assign keep_q = keep_reg;
    assign med_q = med_reg;
endmodule

// ===== hdl/ctmm_merge.sv =====
// Merge: sum kept lanes and divide by kept count, or pick the median lane; empty gives zero
`timescale 1ns / 1ps
module ctmm_merge (
    input  logic aclk,
    input  logic en1,
    input  logic en2,
    input  logic en3,
    input  ctmm_pkg::val_t val_q [ctmm_pkg::MAX_AGENTS],
    input  logic [ctmm_pkg::MAX_AGENTS-1:0] keep_q,
    input  logic [ctmm_pkg::MAX_AGENTS-1:0] med_q,
    input  ctmm_pkg::ctl_t ctl_in,
    output ctmm_pkg::val_t aggregate,
    output logic empty_after_trim
);
    ctmm_pkg::sum_t sum_c, sum_reg;
    ctmm_pkg::val_t med_c, med_reg, med2_reg;
    ctmm_pkg::ctl_t ctl_reg, ctl2_reg;
    logic [ctmm_pkg::SUM_W-1:0] mag;
    logic [ctmm_pkg::RECIP_W-1:0] rcp;
    logic [ctmm_pkg::SUM_W+ctmm_pkg::RECIP_LO_W-1:0] plo_reg;
    logic [ctmm_pkg::SUM_W+ctmm_pkg::RECIP_W-ctmm_pkg::RECIP_LO_W-1:0] phi_reg;
    logic neg_reg;
    logic [ctmm_pkg::SUM_W+ctmm_pkg::RECIP_W-1:0] prod;
    logic [ctmm_pkg::SUM_W-1:0] q;
    ctmm_pkg::val_t res;
    ctmm_pkg::val_t agg_reg;
    logic empty_reg;

    always_comb begin
        sum_c = '0;
        med_c = '0;
        for (int i = 0; i < ctmm_pkg::MAX_AGENTS; i++) begin
            if (keep_q[i]) sum_c = sum_c + ctmm_pkg::SUM_W'(val_q[i]);
            if (med_q[i]) med_c = val_q[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            sum_reg <= sum_c;
            med_reg <= med_c;
            ctl_reg <= ctl_in;
        end
    end

    // magnitude times reciprocal, exact for |sum| < 2^35 and divisor <= 8
    always_comb begin
        mag = sum_reg[ctmm_pkg::SUM_W-1] ? -sum_reg : sum_reg;
        rcp = ctmm_pkg::recip(ctl_reg.kept);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            plo_reg <= mag * rcp[ctmm_pkg::RECIP_LO_W-1:0];
            phi_reg <= mag * rcp[ctmm_pkg::RECIP_W-1:ctmm_pkg::RECIP_LO_W];
            neg_reg <= sum_reg[ctmm_pkg::SUM_W-1];
            med2_reg <= med_reg;
            ctl2_reg <= ctl_reg;
        end
    end

    always_comb begin
        prod = {{(ctmm_pkg::RECIP_W-ctmm_pkg::RECIP_LO_W){1'b0}}, plo_reg} +
               {phi_reg, {ctmm_pkg::RECIP_LO_W{1'b0}}};
        q = prod[ctmm_pkg::RECIP_SH +: ctmm_pkg::SUM_W];
        if (neg_reg) q = -q;
        if (ctl2_reg.empty) res = '0;
        else if (ctl2_reg.mode == ctmm_pkg::MODE_MEDIAN) res = med2_reg;
        else res = q[ctmm_pkg::VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            agg_reg <= res;
            empty_reg <= ctl2_reg.empty;
        end
    end

    assign aggregate = agg_reg;
    assign empty_after_trim = empty_reg;
endmodule

// ===== hdl/coordinate_trimmed_mean_median.sv =====
// Top level: coordinate-wise median / trimmed mean over up to eight agents
//  channel | ports                                           | dir
//  s_      | s_valid s_ready s_value_0..7                    | in
//  m_      | m_valid m_ready m_aggregate m_empty_after_trim  | out
//  cfg     | cfg_valid cfg_ready cfg_*                       | in
// One item per cycle while the output is not stalled; stages: lane rank, lane merge, split multiply, add.
// Throughput set by the four-stage pipeline that stalls as a whole.
// Synchronous active-low reset clears the valid bits and sets the config registers to their defaults.
// A stalled output holds all stages.
`timescale 1ns / 1ps
module coordinate_trimmed_mean_median (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [31:0] s_value_0,
    input  logic signed [31:0] s_value_1,
    input  logic signed [31:0] s_value_2,
    input  logic signed [31:0] s_value_3,
    input  logic signed [31:0] s_value_4,
    input  logic signed [31:0] s_value_5,
    input  logic signed [31:0] s_value_6,
    input  logic signed [31:0] s_value_7,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [31:0] m_aggregate,
    output logic m_empty_after_trim,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    ctmm_pkg::val_t vals [ctmm_pkg::MAX_AGENTS];
    ctmm_pkg::val_t lane_val [ctmm_pkg::MAX_AGENTS];
    logic [ctmm_pkg::RANK_W-1:0] lane_rank [ctmm_pkg::MAX_AGENTS];
    logic [ctmm_pkg::MAX_AGENTS-1:0] keep, med;
    logic [3:0] count_reg;
    logic mode_reg;
    logic [2:0] trim_reg;
    ctmm_pkg::cfg_t cfg;
    ctmm_pkg::ctl_t ctl_c, ctl_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv;
    logic [ctmm_pkg::CNT_W-1:0] twot;

    assign vals[0] = s_value_0;
    assign vals[1] = s_value_1;
    assign vals[2] = s_value_2;
    assign vals[3] = s_value_3;
    assign vals[4] = s_value_4;
    assign vals[5] = s_value_5;
    assign vals[6] = s_value_6;
    assign vals[7] = s_value_7;

    assign adv = !v4_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = v4_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg.n = (count_reg > 4'(ctmm_pkg::MAX_AGENTS)) ? ctmm_pkg::CNT_W'(ctmm_pkg::MAX_AGENTS)
                                                    : count_reg[ctmm_pkg::CNT_W-1:0];
        cfg.mode = mode_reg;
        cfg.trim = trim_reg;
        twot = {trim_reg, 1'b0};
        ctl_c.mode = mode_reg;
        ctl_c.kept = cfg.n - twot;
        ctl_c.empty = (cfg.n == '0) ||
                      (mode_reg == ctmm_pkg::MODE_TRIM && {1'b0, twot} >= {1'b0, cfg.n});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd8;
            mode_reg <= ctmm_pkg::MODE_MEDIAN;
            trim_reg <= 3'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ctmm_pkg::REG_AGENT_COUNT: count_reg <= cfg_data[3:0];
                ctmm_pkg::REG_MODE: mode_reg <= cfg_data[0];
                ctmm_pkg::REG_TRIM_COUNT: trim_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) ctl_reg <= ctl_c;
    end

    for (genvar g = 0; g < ctmm_pkg::MAX_AGENTS; g++) begin : g_lane
        ctmm_lane u_lane (
            .aclk(aclk),
            .en(adv),
            .lane_idx(ctmm_pkg::RANK_W'(g)),
            .vals(vals),
            .cfg(cfg),
            .val_q(lane_val[g]),
            .rank_q(lane_rank[g]),
            .keep_q(keep[g]),
            .med_q(med[g])
        );
    end

    ctmm_merge u_merge (
        .aclk(aclk),
        .en1(adv),
        .en2(adv),
        .en3(adv),
        .val_q(lane_val),
        .keep_q(keep),
        .med_q(med),
        .ctl_in(ctl_reg),
        .aggregate(m_aggregate),
        .empty_after_trim(m_empty_after_trim)
    );

`ifndef SYNTH
    a_med_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> $onehot0(med)) else $error("median lanes not unique");
    a_rank_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && ctl_reg.kept == 4'd8 && !ctl_reg.empty
        |-> lane_rank[0] != lane_rank[1]) else $error("rank collision");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_aggregate)) else $error("output moved in stall");
`endif
endmodule

// ===== dv/ctmm_checker.sv =====
// Checker: watches the input, result and register channels, predicts each aggregate and compares
`timescale 1ns / 1ps
module ctmm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic signed [31:0] s_value_0,
    input  logic signed [31:0] s_value_1,
    input  logic signed [31:0] s_value_2,
    input  logic signed [31:0] s_value_3,
    input  logic signed [31:0] s_value_4,
    input  logic signed [31:0] s_value_5,
    input  logic signed [31:0] s_value_6,
    input  logic signed [31:0] s_value_7,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic signed [31:0] m_aggregate,
    input  logic        m_empty_after_trim,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    typedef struct {
        logic signed [31:0] aggregate;
        logic               empty;
    } agg_result_t;

    logic [3:0] agent_count_q;
    logic       mode_q;
    logic [2:0] trim_count_q;
    agg_result_t pending_aggs[$];

    function automatic agg_result_t aggregate_column(input logic signed [31:0] vals_in[8]);
        agg_result_t r;
        logic signed [31:0] v[8];
        logic signed [31:0] key;
        logic signed [63:0] sum;
        int n;
        int t;
        int j;
        n = (agent_count_q > 8) ? 8 : agent_count_q;
        t = trim_count_q;
        r.aggregate = '0;
        r.empty = 1'b0;
        sum = '0;
        for (int i = 0; i < 8; i++) v[i] = vals_in[i];
        for (int i = 1; i < n; i++) begin
            key = v[i];
            j = i;
            while (j > 0 && v[j-1] > key) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = key;
        end
        if (n == 0) begin
            r.empty = 1'b1;
        end else if (mode_q == ctmm_pkg::MODE_MEDIAN) begin
            r.aggregate = v[n/2];
        end else if (2 * t >= n) begin
            r.empty = 1'b1;
        end else begin
            for (int i = t; i < n - t; i++) sum += 64'(v[i]);
            r.aggregate = 32'(sum / 64'(n - 2 * t));
        end
        return r;
    endfunction

    assign pending_count = pending_aggs.size();

    always @(posedge aclk) begin
        logic signed [31:0] col[8];
        agg_result_t exp_r;
        if (!aresetn) begin
            agent_count_q <= 4'd8;
            mode_q <= ctmm_pkg::MODE_MEDIAN;
            trim_count_q <= 3'd1;
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_aggs.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction: aggregate %0d empty %0b",
                                 m_aggregate, m_empty_after_trim);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = pending_aggs.pop_front();
                    if (exp_r.aggregate !== m_aggregate || exp_r.empty !== m_empty_after_trim) begin
                        if (fail_count < 10)
                            $display("mismatch: expected aggregate %0d empty %0b, got %0d %0b",
                                     exp_r.aggregate, exp_r.empty, m_aggregate,
                                     m_empty_after_trim);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                col = '{s_value_0, s_value_1, s_value_2, s_value_3,
                        s_value_4, s_value_5, s_value_6, s_value_7};
                pending_aggs = {pending_aggs, aggregate_column(col)};
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ctmm_pkg::REG_AGENT_COUNT: agent_count_q <= cfg_data[3:0];
                    ctmm_pkg::REG_MODE:        mode_q <= cfg_data[0];
                    ctmm_pkg::REG_TRIM_COUNT:  trim_count_q <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/tb_coordinate_trimmed_mean_median.sv =====
// Testbench top: drives columns and register writes into the block and reports the verdict
`timescale 1ns / 1ps
module tb_coordinate_trimmed_mean_median;
    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [31:0] s_vals[8];
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_aggregate;
    logic m_empty_after_trim;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    int fail_count;
    int pending_count;
    bit stim_done;
    bit sink_no_stall;

    coordinate_trimmed_mean_median u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value_0(s_vals[0]), .s_value_1(s_vals[1]), .s_value_2(s_vals[2]),
        .s_value_3(s_vals[3]), .s_value_4(s_vals[4]), .s_value_5(s_vals[5]),
        .s_value_6(s_vals[6]), .s_value_7(s_vals[7]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_aggregate(m_aggregate), .m_empty_after_trim(m_empty_after_trim),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ctmm_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value_0(s_vals[0]), .s_value_1(s_vals[1]), .s_value_2(s_vals[2]),
        .s_value_3(s_vals[3]), .s_value_4(s_vals[4]), .s_value_5(s_vals[5]),
        .s_value_6(s_vals[6]), .s_value_7(s_vals[7]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_aggregate(m_aggregate), .m_empty_after_trim(m_empty_after_trim),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_config(input int cnt, input int md, input int trim);
        write_reg(ctmm_pkg::REG_AGENT_COUNT, 32'(cnt));
        write_reg(ctmm_pkg::REG_MODE, 32'(md));
        write_reg(ctmm_pkg::REG_TRIM_COUNT, 32'(trim));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value(input int style);
        logic [31:0] v;
        case (style)
            0: v = $urandom;
            1: v = 32'($signed($urandom_range(0, 40)) - 20);
            2: v = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            default: v = {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
        endcase
        return v;
    endfunction

    task automatic send_column(input logic [31:0] vals[8], input bit no_gap);
        int idle;
        idle = no_gap ? 0 : $urandom_range(0, 11);
        if (idle != 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        for (int i = 0; i < 8; i++) s_vals[i] <= vals[i];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count, input bit no_gap);
        logic [31:0] col[8];
        int style;
        for (int k = 0; k < count; k++) begin
            style = $urandom_range(0, 3);
            for (int i = 0; i < 8; i++) col[i] = pick_value(style);
            send_column(col, no_gap);
        end
    endtask

    initial begin
        s_valid = 1'b0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 8; i++) s_vals[i] = '0;
        stim_done = 1'b0;
        sink_no_stall = 1'b0;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_column('{32'h7fff_ffff, 32'h8000_0000, 0, 1, 32'hffff_ffff, 5, 9, 32'h7fff_ffff}, 0);
        send_random(2, 0);
        drain_pipeline();
        set_config(8, ctmm_pkg::MODE_TRIM, 0);
        send_column('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 0);
        send_column('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001}, 0);
        send_column('{-7, 0, 0, 0, 0, 0, 0, 0}, 0);
        send_column('{-1, 32'haaaa_aaaa, 32'h5555_5555, 3, -3, 100, 0, 2}, 0);
        drain_pipeline();
        set_config(0, ctmm_pkg::MODE_MEDIAN, 0);
        send_random(2, 0);
        drain_pipeline();
        set_config(15, ctmm_pkg::MODE_TRIM, 4);
        send_random(2, 0);
        drain_pipeline();
        set_config(9, ctmm_pkg::MODE_TRIM, 3);
        send_random(2, 0);
        drain_pipeline();
        set_config(3, ctmm_pkg::MODE_TRIM, 1);
        send_random(2, 0);
        drain_pipeline();
        set_config(1, ctmm_pkg::MODE_MEDIAN, 7);
        send_random(2, 0);
        drain_pipeline();
        set_config(2, ctmm_pkg::MODE_TRIM, 1);
        send_random(2, 0);
        drain_pipeline();
        set_config(7, ctmm_pkg::MODE_TRIM, 2);
        send_random(2, 0);

        for (int phase = 0; phase < 28; phase++) begin
            drain_pipeline();
            set_config($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 7));
            sink_no_stall = (phase % 5 == 0);
            send_random(50, phase % 5 == 0);
        end
        stim_done = 1'b1;
        drain_pipeline();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int idle;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (sink_no_stall || stim_done) begin
                m_ready <= 1'b1;
            end else begin
                idle = $urandom_range(0, 11);
                if (idle != 0) begin
                    m_ready <= 1'b0;
                    repeat (idle) @(negedge aclk);
                end
                m_ready <= 1'b1;
                do @(posedge aclk); while (!m_valid);
            end
        end
    end
endmodule

// ===== coordinate_trimmed_mean_median.f =====
hdl/ctmm_pkg.sv
hdl/ctmm_lane.sv
hdl/ctmm_merge.sv
hdl/coordinate_trimmed_mean_median.sv
dv/ctmm_checker.sv
dv/tb_coordinate_trimmed_mean_median.sv
